>>> rtl/pbac_pkg.sv
// ----------------------------------------------------------------------------
// pbac_pkg
// Shared types, widths and codes for the proxy bypass address classifier.
// ----------------------------------------------------------------------------
package pbac_pkg;

  localparam int MAX_RULES    = 64;   // cells in the rule chain, 1 to 64
  localparam int ADDR_W       = 64;
  localparam int RULE_IDX_W   = 6;
  localparam int PREFIX_W     = 8;
  localparam int CAT_W        = 3;
  localparam int CELL_IDX_W   = 8;    // holds any cell number up to 255
  localparam int RULE_COUNT_W = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 7;

  // input modes
  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_WRITE    = 1'b1;

  // result categories
  localparam logic [CAT_W-1:0] CAT_NONE     = 3'd0;
  localparam logic [CAT_W-1:0] CAT_LOOPBACK = 3'd1;
  localparam logic [CAT_W-1:0] CAT_PRIVATE  = 3'd2;
  localparam logic [CAT_W-1:0] CAT_LAN      = 3'd3;
  localparam logic [CAT_W-1:0] CAT_CGNAT    = 3'd4;
  localparam logic [CAT_W-1:0] CAT_CIDR     = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_VALID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LOOPBACK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PRIVATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LINK_LOCAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_CGNAT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT        = 3'd5;

  // item as it travels down the chain
  typedef struct packed {
    logic                  mode;
    logic                  is_ipv6;
    logic [ADDR_W-1:0]     address_high;
    logic [ADDR_W-1:0]     address_low;
    logic [RULE_IDX_W-1:0] rule_index;
    logic [PREFIX_W-1:0]   pfx_len;
    logic                  skip;   // policy invalid: no rule may hit
    logic [CAT_W-1:0]      cat;    // first hit so far, CAT_NONE if none
  } item_t;

  // class check controls
  typedef struct packed {
    logic policy_valid;
    logic enable_loopback;
    logic enable_private;
    logic enable_link_local;
    logic enable_cgnat;
  } cls_cfg_t;

endpackage

>>> rtl/pbac_ifs.sv
// ----------------------------------------------------------------------------
// pbac_ifs
// Valid/ready channels for address items and classification results.
// ----------------------------------------------------------------------------
interface pbac_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic                            is_ipv6;
  logic [pbac_pkg::ADDR_W-1:0]     address_high;
  logic [pbac_pkg::ADDR_W-1:0]     address_low;
  logic [pbac_pkg::RULE_IDX_W-1:0] rule_index;
  logic [pbac_pkg::PREFIX_W-1:0]   pfx_len;

  modport source (
    output valid, mode, is_ipv6, address_high, address_low, rule_index, pfx_len,
    input  ready
  );
  modport sink (
    input  valid, mode, is_ipv6, address_high, address_low, rule_index, pfx_len,
    output ready
  );
endinterface

interface pbac_out_if;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [pbac_pkg::CAT_W-1:0] category;

  modport source (
    output valid, matched, category,
    input  ready
  );
  modport sink (
    input  valid, matched, category,
    output ready
  );
endinterface

>>> rtl/proxy_bypass_address_classifier_top.sv
// ----------------------------------------------------------------------------
// proxy_bypass_address_classifier_top
// Bypass classifier: class checks in a head stage, then a chain of CIDR
// rule cells that items and table writes flow through in order.
//
//   channel | dir | transfer                    | payload
//   in_ch   | in  | valid & ready               | mode, is_ipv6, address, rule, prefix
//   out_ch  | out | valid & ready               | matched, category
//   cfg_*   | in  | cfg_we at the clock edge    | cfg_index, cfg_data
//
// One item a cycle enters while the output is not stalled; its result is offered
// after the input transfer, through MAX_RULES + 1 register stages.
// Latency is set by the head stage plus the rule chain, one cell per entry.
// An output stall freezes the whole chain; in_ch.ready follows it.
// Reset clears the valid bits and sets the configuration registers to defaults; rule
// entries hold no defined value until written.
// ----------------------------------------------------------------------------
module proxy_bypass_address_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  pbac_in_if.sink                        in_ch,
  pbac_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pbac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbac_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int N = pbac_pkg::MAX_RULES;

  pbac_pkg::cls_cfg_t               cls_cfg_r;
  logic [pbac_pkg::RULE_COUNT_W-1:0] rule_count_r;

  logic            adv;
  pbac_pkg::item_t in_item;
  pbac_pkg::item_t stg [0:N];
  logic [N:0]      vld;
  logic [N-1:0]    rule_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_cfg_r.policy_valid      <= 1'b1;
      cls_cfg_r.enable_loopback   <= 1'b1;
      cls_cfg_r.enable_private    <= 1'b0;
      cls_cfg_r.enable_link_local <= 1'b0;
      cls_cfg_r.enable_cgnat      <= 1'b0;
      rule_count_r                <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbac_pkg::REG_POLICY_VALID:      cls_cfg_r.policy_valid      <= cfg_data[0];
        pbac_pkg::REG_ENABLE_LOOPBACK:   cls_cfg_r.enable_loopback   <= cfg_data[0];
        pbac_pkg::REG_ENABLE_PRIVATE:    cls_cfg_r.enable_private    <= cfg_data[0];
        pbac_pkg::REG_ENABLE_LINK_LOCAL: cls_cfg_r.enable_link_local <= cfg_data[0];
        pbac_pkg::REG_ENABLE_CGNAT:      cls_cfg_r.enable_cgnat      <= cfg_data[0];
        pbac_pkg::REG_RULE_COUNT:        rule_count_r <= cfg_data[pbac_pkg::RULE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !vld[N] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    in_item.mode         = in_ch.mode;
    in_item.is_ipv6      = in_ch.is_ipv6;
    in_item.address_high = in_ch.address_high;
    in_item.address_low  = in_ch.address_low;
    in_item.rule_index   = in_ch.rule_index;
    in_item.pfx_len      = in_ch.pfx_len;
    in_item.skip         = 1'b0;
    in_item.cat          = pbac_pkg::CAT_NONE;
  end

  pbac_class u_class (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cls_cfg_r),
    .vld_i  (in_ch.valid),
    .item_i (in_item),
    .vld_o  (vld[0]),
    .item_o (stg[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    // entries at or above rule_count are out of use
    assign rule_en[i] = pbac_pkg::CELL_IDX_W'(i) < {1'b0, rule_count_r};

    pbac_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .en     (rule_en[i]),
      .idx    (pbac_pkg::CELL_IDX_W'(i)),
      .vld_i  (vld[i]),
      .item_i (stg[i]),
      .vld_o  (vld[i+1]),
      .item_o (stg[i+1])
    );
  end

  assign out_ch.valid    = vld[N];
  assign out_ch.matched  = stg[N].cat != pbac_pkg::CAT_NONE;
  assign out_ch.category = stg[N].cat;

  // chain holds still while the result is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld))
    else $error("chain moved during output stall");

  // table writes never report a hit
  a_write_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] && stg[N].mode == pbac_pkg::MODE_WRITE |-> !out_ch.matched)
    else $error("table write produced a match");

  // invalid policy items leave the chain unmatched
  a_skip_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] && stg[N].skip |-> stg[N].cat == pbac_pkg::CAT_NONE)
    else $error("match under invalid policy");

  // a result is either a known category or none
  a_cat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.category <= pbac_pkg::CAT_CIDR)
    else $error("category out of range");

endmodule

>>> rtl/pbac_class.sv
// ----------------------------------------------------------------------------
// pbac_class
// Head stage: fixed class checks (loopback, private, link-local, CGNAT).
// ----------------------------------------------------------------------------
module pbac_class (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  pbac_pkg::cls_cfg_t cfg,
  input  logic               vld_i,
  input  pbac_pkg::item_t    item_i,
  output logic               vld_o,
  output pbac_pkg::item_t    item_o
);

  logic            vld_r;
  pbac_pkg::item_t item_r, item_nxt;
  logic [7:0]      b0, b1;
  logic            v6;
  logic            hit_loop, hit_priv, hit_ll, hit_cgnat;

  always_comb begin
    v6 = item_i.is_ipv6;
    if (v6) begin
      b0 = item_i.address_high[63:56];
      b1 = item_i.address_high[55:48];
    end else begin
      b0 = item_i.address_low[31:24];
      b1 = item_i.address_low[23:16];
    end

    hit_loop  = v6 ? (item_i.address_high == '0 && item_i.address_low == 64'd1)
                   : (b0 == 8'd127);
    hit_priv  = v6 ? ((b0 & 8'hfe) == 8'hfc)
                   : (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
                      (b0 == 8'd192 && b1 == 8'd168));
    hit_ll    = v6 ? (b0 == 8'hfe && (b1 & 8'hc0) == 8'h80)
                   : (b0 == 8'd169 && b1 == 8'd254);
    hit_cgnat = !v6 && b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127;

    item_nxt      = item_i;
    item_nxt.skip = !cfg.policy_valid;
    item_nxt.cat  = pbac_pkg::CAT_NONE;
    if (item_i.mode == pbac_pkg::MODE_CLASSIFY && cfg.policy_valid) begin
      if (cfg.enable_loopback && hit_loop) begin
        item_nxt.cat = pbac_pkg::CAT_LOOPBACK;
      end else if (cfg.enable_private && hit_priv) begin
        item_nxt.cat = pbac_pkg::CAT_PRIVATE;
      end else if (cfg.enable_link_local && hit_ll) begin
        item_nxt.cat = pbac_pkg::CAT_LAN;
      end else if (cfg.enable_cgnat && hit_cgnat) begin
        item_nxt.cat = pbac_pkg::CAT_CGNAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

>>> rtl/pbac_cell.sv
// ----------------------------------------------------------------------------
// pbac_cell
// One CIDR rule entry and one chain stage: stores the rule on a matching
// write transfer and marks passing classify items that hit it.
// ----------------------------------------------------------------------------
module pbac_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            en,   // entry lies below rule_count
  input  logic [pbac_pkg::CELL_IDX_W-1:0] idx,
  input  logic                            vld_i,
  input  pbac_pkg::item_t                 item_i,
  output logic                            vld_o,
  output pbac_pkg::item_t                 item_o
);

  logic                          vld_r;
  pbac_pkg::item_t               item_r, item_nxt;
  logic                          fam_r;
  logic [pbac_pkg::ADDR_W-1:0]   net_hi_r, net_lo_r;
  logic [pbac_pkg::PREFIX_W-1:0] pfx_r;

  logic [5:0]                    p4;
  logic [pbac_pkg::PREFIX_W-1:0] p6;
  logic [31:0]                   m4;
  logic [pbac_pkg::ADDR_W-1:0]   mh, ml;
  logic                          hit, wr;

  always_comb begin
    // over-long prefixes act as the full family length
    p4 = (pfx_r > 8'd32) ? 6'd32 : pfx_r[5:0];
    p6 = (pfx_r > 8'd128) ? 8'd128 : pfx_r;
    m4 = ~(32'hffff_ffff >> p4);
    mh = (p6 >= 8'd64) ? '1 : ~({pbac_pkg::ADDR_W{1'b1}} >> p6[5:0]);
    if (p6 >= 8'd128) begin
      ml = '1;
    end else if (p6 > 8'd64) begin
      ml = ~({pbac_pkg::ADDR_W{1'b1}} >> p6[5:0]);
    end else begin
      ml = '0;
    end

    if (fam_r != item_i.is_ipv6) begin
      hit = 1'b0;
    end else if (item_i.is_ipv6) begin
      hit = (((item_i.address_high ^ net_hi_r) & mh) == '0) &&
            (((item_i.address_low ^ net_lo_r) & ml) == '0);
    end else begin
      hit = ((item_i.address_low[31:0] ^ net_lo_r[31:0]) & m4) == '0;
    end

    item_nxt = item_i;
    if (item_i.mode == pbac_pkg::MODE_CLASSIFY && !item_i.skip &&
        item_i.cat == pbac_pkg::CAT_NONE && en && hit) begin
      item_nxt.cat = pbac_pkg::CAT_CIDR;
    end

    wr = adv && vld_i && item_i.mode == pbac_pkg::MODE_WRITE &&
         {{(pbac_pkg::CELL_IDX_W-pbac_pkg::RULE_IDX_W){1'b0}}, item_i.rule_index} == idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      item_r <= item_nxt;
    end
    if (wr) begin
      fam_r    <= item_i.is_ipv6;
      net_hi_r <= item_i.address_high;
      net_lo_r <= item_i.address_low;
      pfx_r    <= item_i.pfx_len;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proxy bypass address classifier. Loads the
// CIDR table, runs directed edge addresses, then random phases under varied
// register settings and random stalls on both channels. Each result is
// checked against an in-bench predictor of the class and rule checks.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 250;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [pbac_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;   // no register behind it

  typedef struct packed {
    logic                            mode;
    logic                            is_ipv6;
    logic [pbac_pkg::ADDR_W-1:0]     address_high;
    logic [pbac_pkg::ADDR_W-1:0]     address_low;
    logic [pbac_pkg::RULE_IDX_W-1:0] rule_index;
    logic [pbac_pkg::PREFIX_W-1:0]   pfx_len;
  } addr_req_t;

  typedef struct packed {
    logic                       matched;
    logic [pbac_pkg::CAT_W-1:0] category;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [pbac_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pbac_pkg::CFG_DATA_W-1:0] cfg_data;

  pbac_in_if  addr_ch ();
  pbac_out_if verdict_ch ();

  proxy_bypass_address_classifier_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (addr_ch),
    .out_ch    (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  bit                              policy_valid_q;
  bit                              loopback_en_q;
  bit                              private_en_q;
  bit                              link_local_en_q;
  bit                              cgnat_en_q;
  logic [pbac_pkg::RULE_COUNT_W-1:0] rule_count_q;
  logic [pbac_pkg::ADDR_W-1:0]     rule_net_hi_q [pbac_pkg::MAX_RULES];
  logic [pbac_pkg::ADDR_W-1:0]     rule_net_lo_q [pbac_pkg::MAX_RULES];
  logic [pbac_pkg::PREFIX_W-1:0]   rule_prefix_q [pbac_pkg::MAX_RULES];
  logic                            rule_v6_q     [pbac_pkg::MAX_RULES];

  addr_req_t backlog [$];
  verdict_t  expected_verdicts [$];
  int        mismatches;

  logic addr_xfer;
  logic verdict_xfer;
  bit   in_burst;
  bit   out_burst;
  int   send_gap;
  int   take_gap;
  int   hold_left;
  int   holds_asked;
  int   holds_served;

  // ---------------------------------------------------------------- predictor
  function automatic bit rule_covers(int i, addr_req_t r);
    int           p;
    logic [31:0]  keep4;
    logic [127:0] keep6;
    if (rule_v6_q[i] != r.is_ipv6) return 1'b0;
    p = rule_prefix_q[i];
    if (!r.is_ipv6) begin
      if (p > 32) p = 32;
      keep4 = (p == 0) ? 32'd0 : ~32'd0 << (32 - p);
      return ((r.address_low[31:0] ^ rule_net_lo_q[i][31:0]) & keep4) == 32'd0;
    end
    if (p > 128) p = 128;
    keep6 = (p == 0) ? 128'd0 : ~128'd0 << (128 - p);
    return (({r.address_high, r.address_low} ^ {rule_net_hi_q[i], rule_net_lo_q[i]})
            & keep6) == 128'd0;
  endfunction

  function automatic logic [pbac_pkg::CAT_W-1:0] bypass_category(addr_req_t r);
    logic [7:0] b0;
    logic [7:0] b1;
    int         n;
    b0 = r.is_ipv6 ? r.address_high[63:56] : r.address_low[31:24];
    b1 = r.is_ipv6 ? r.address_high[55:48] : r.address_low[23:16];
    if (loopback_en_q && (r.is_ipv6 ? (r.address_high == 64'd0 && r.address_low == 64'd1)
                                    : b0 == 8'd127))
      return pbac_pkg::CAT_LOOPBACK;
    if (private_en_q && (r.is_ipv6 ? b0[7:1] == 7'h7e
                                   : (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31)
                                      || (b0 == 8'd192 && b1 == 8'd168))))
      return pbac_pkg::CAT_PRIVATE;
    if (link_local_en_q && (r.is_ipv6 ? (b0 == 8'hfe && b1[7:6] == 2'b10)
                                      : (b0 == 8'd169 && b1 == 8'd254)))
      return pbac_pkg::CAT_LAN;
    if (cgnat_en_q && !r.is_ipv6 && b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127)
      return pbac_pkg::CAT_CGNAT;
    n = (rule_count_q > pbac_pkg::MAX_RULES) ? pbac_pkg::MAX_RULES : int'(rule_count_q);
    for (int i = 0; i < n; i++)
      if (rule_covers(i, r)) return pbac_pkg::CAT_CIDR;
    return pbac_pkg::CAT_NONE;
  endfunction

  function automatic verdict_t predict_verdict(addr_req_t r);
    verdict_t v;
    v.category = pbac_pkg::CAT_NONE;
    if (r.mode == pbac_pkg::MODE_WRITE) begin
      if (r.rule_index < pbac_pkg::MAX_RULES) begin
        rule_net_hi_q[r.rule_index] = r.address_high;
        rule_net_lo_q[r.rule_index] = r.address_low;
        rule_prefix_q[r.rule_index] = r.pfx_len;
        rule_v6_q[r.rule_index]     = r.is_ipv6;
      end
    end else if (policy_valid_q) begin
      v.category = bypass_category(r);
    end
    v.matched = (v.category != pbac_pkg::CAT_NONE);
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic addr_req_t scramble();
    addr_req_t r;
    r.mode         = pbac_pkg::MODE_CLASSIFY;
    r.is_ipv6      = 1'($urandom_range(0, 1));
    r.address_high = rand64();
    r.address_low  = rand64();
    r.rule_index   = pbac_pkg::RULE_IDX_W'($urandom);
    r.pfx_len      = pbac_pkg::PREFIX_W'($urandom);
    return r;
  endfunction

  function automatic addr_req_t random_rule(int idx);
    addr_req_t r;
    r            = scramble();
    r.mode       = pbac_pkg::MODE_WRITE;
    r.rule_index = pbac_pkg::RULE_IDX_W'(idx);
    case ($urandom_range(0, 9))
      0:       r.pfx_len = '0;
      1:       r.pfx_len = pbac_pkg::PREFIX_W'($urandom_range(r.is_ipv6 ? 129 : 33, 255));
      default: r.pfx_len = pbac_pkg::PREFIX_W'($urandom_range(1, r.is_ipv6 ? 128 : 32));
    endcase
    return r;
  endfunction

  // address inside or just beside one of the rules in use
  function automatic addr_req_t near_rule_address();
    addr_req_t    r;
    int           i;
    int           n;
    int           p;
    int           flip;
    logic [127:0] keep;
    logic [127:0] a;
    r = scramble();
    n = (rule_count_q > pbac_pkg::MAX_RULES) ? pbac_pkg::MAX_RULES : int'(rule_count_q);
    i = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, pbac_pkg::MAX_RULES - 1);
    p = rule_prefix_q[i];
    r.is_ipv6 = rule_v6_q[i] ^ ($urandom_range(0, 9) == 0);
    if (rule_v6_q[i]) begin
      if (p > 128) p = 128;
      keep = (p == 0) ? 128'd0 : ~128'd0 << (128 - p);
    end else begin
      if (p > 32) p = 32;
      keep = (p == 0) ? 128'd0 : {96'd0, ~32'd0 << (32 - p)};
    end
    a = {rule_net_hi_q[i], rule_net_lo_q[i]} ^ ({r.address_high, r.address_low} & ~keep);
    if (p > 0 && $urandom_range(0, 4) == 0) begin
      flip = (rule_v6_q[i] ? 127 : 31) - int'($urandom_range(0, p - 1));
      a[flip] = ~a[flip];
    end
    {r.address_high, r.address_low} = a;
    return r;
  endfunction

  // addresses on and around the fixed class ranges
  function automatic addr_req_t class_edge_address();
    addr_req_t  r;
    logic [7:0] b0;
    logic [7:0] b1;
    r  = scramble();
    b0 = r.address_low[31:24];
    b1 = r.address_low[23:16];
    if (!r.is_ipv6) begin
      case ($urandom_range(0, 6))
        0: b0 = 8'd127;
        1: b0 = 8'd10;
        2: begin b0 = 8'd172; b1 = 8'($urandom_range(14, 33)); end
        3: begin
          b0 = 8'd192;
          b1 = $urandom_range(0, 1) ? 8'd168 : 8'($urandom_range(166, 170));
        end
        4: begin b0 = 8'd169; b1 = 8'($urandom_range(252, 255)); end
        5: begin
          b0 = 8'd100;
          b1 = $urandom_range(0, 1) ? 8'($urandom_range(62, 66)) : 8'($urandom_range(125, 129));
        end
        default: b0 = 8'($urandom_range(8, 12));
      endcase
      r.address_low[31:16] = {b0, b1};
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          r.address_high = 64'd0;
          r.address_low  = $urandom_range(0, 1) ? 64'd1 : 64'($urandom_range(0, 3));
          if ($urandom_range(0, 4) == 0) r.address_high[$urandom_range(0, 63)] = 1'b1;
        end
        1: r.address_high[63:57] = 7'h7e;
        2: r.address_high[63:54] = 10'h3fa;
        3: r.address_high[63:56] = 8'hfe;
        4: r.address_high[63:56] = $urandom_range(0, 1) ? 8'hfb : 8'hff;
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic addr_req_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return random_rule($urandom_range(0, pbac_pkg::MAX_RULES - 1));
    if (pick < 55) return near_rule_address();
    if (pick < 85) return class_edge_address();
    return scramble();
  endfunction

  task automatic queue_addr(input logic v6, input logic [127:0] a);
    addr_req_t r;
    r         = scramble();
    r.is_ipv6 = v6;
    if (v6) {r.address_high, r.address_low} = a;
    else r.address_low[31:0] = a[31:0];
    backlog.insert(backlog.size(), r);
  endtask

  task automatic queue_rule(input int idx, input logic v6, input logic [127:0] net,
                            input logic [pbac_pkg::PREFIX_W-1:0] plen);
    addr_req_t r;
    r         = random_rule(idx);
    r.is_ipv6 = v6;
    r.pfx_len = plen;
    if (v6) {r.address_high, r.address_low} = net;
    else r.address_low[31:0] = net[31:0];
    backlog.insert(backlog.size(), r);
  endtask

  // ---------------------------------------------------------------- config
  task automatic write_reg(input logic [pbac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pbac_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      pbac_pkg::REG_POLICY_VALID:      policy_valid_q  = val[0];
      pbac_pkg::REG_ENABLE_LOOPBACK:   loopback_en_q   = val[0];
      pbac_pkg::REG_ENABLE_PRIVATE:    private_en_q    = val[0];
      pbac_pkg::REG_ENABLE_LINK_LOCAL: link_local_en_q = val[0];
      pbac_pkg::REG_ENABLE_CGNAT:      cgnat_en_q      = val[0];
      pbac_pkg::REG_RULE_COUNT:        rule_count_q    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // single-bit registers get random padding above bit 0
  task automatic write_policy(input bit pv, lb, pr, ll, cg,
                              input logic [pbac_pkg::RULE_COUNT_W-1:0] cnt);
    write_reg(pbac_pkg::REG_POLICY_VALID,      {6'($urandom), pv});
    write_reg(pbac_pkg::REG_ENABLE_LOOPBACK,   {6'($urandom), lb});
    write_reg(pbac_pkg::REG_ENABLE_PRIVATE,    {6'($urandom), pr});
    write_reg(pbac_pkg::REG_ENABLE_LINK_LOCAL, {6'($urandom), ll});
    write_reg(pbac_pkg::REG_ENABLE_CGNAT,      {6'($urandom), cg});
    write_reg(pbac_pkg::REG_RULE_COUNT,        cnt);
  endtask

  task automatic wait_drained();
    while (backlog.size() != 0 || addr_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit press);
    in_burst  = press || ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    if (press) holds_asked++;
    repeat (n_items) backlog.insert(backlog.size(), random_item());
    wait_drained();
  endtask

  function automatic int draw_gap(bit burst);
    if (burst || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin : addr_feeder
    addr_req_t nxt;
    if (!rst_n) begin
      addr_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else if (!addr_ch.valid || addr_xfer) begin
      if (send_gap != 0) begin
        addr_ch.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (backlog.size() != 0) begin
        nxt = backlog.pop_front();
        addr_ch.valid        <= 1'b1;
        addr_ch.mode         <= nxt.mode;
        addr_ch.is_ipv6      <= nxt.is_ipv6;
        addr_ch.address_high <= nxt.address_high;
        addr_ch.address_low  <= nxt.address_low;
        addr_ch.rule_index   <= nxt.rule_index;
        addr_ch.pfx_len      <= nxt.pfx_len;
        send_gap             <= draw_gap(in_burst);
      end else begin
        addr_ch.valid <= 1'b0;
      end
    end
  end

  // result side: per-transfer gaps, plus one long hold-off when asked
  always @(negedge clk) begin : verdict_taker
    int g;
    if (!rst_n) begin
      verdict_ch.ready <= 1'b0;
      take_gap         <= 0;
      hold_left        <= 0;
      holds_served     <= 0;
    end else if (hold_left != 0) begin
      verdict_ch.ready <= 1'b0;
      hold_left        <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      verdict_ch.ready <= 1'b0;
      hold_left        <= HOLD_CYCLES;
      holds_served     <= holds_asked;
    end else begin
      g = verdict_xfer ? draw_gap(out_burst) : take_gap;
      if (g != 0) begin
        verdict_ch.ready <= 1'b0;
        take_gap         <= g - 1;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitors
  always @(posedge clk) begin : addr_monitor
    addr_req_t seen;
    addr_xfer <= rst_n && addr_ch.valid && addr_ch.ready;
    if (rst_n && addr_ch.valid && addr_ch.ready) begin
      seen.mode         = addr_ch.mode;
      seen.is_ipv6      = addr_ch.is_ipv6;
      seen.address_high = addr_ch.address_high;
      seen.address_low  = addr_ch.address_low;
      seen.rule_index   = addr_ch.rule_index;
      seen.pfx_len      = addr_ch.pfx_len;
      expected_verdicts.insert(expected_verdicts.size(), predict_verdict(seen));
    end
  end

  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    verdict_xfer <= rst_n && verdict_ch.valid && verdict_ch.ready;
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result matched=%0b category=%0d",
                 $time, verdict_ch.matched, verdict_ch.category);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_ch.matched !== want.matched) begin
          $display("%0t: matched expected %0b got %0b", $time, want.matched, verdict_ch.matched);
          mismatches++;
        end
        if (verdict_ch.category !== want.category) begin
          $display("%0t: category expected %0d got %0d",
                   $time, want.category, verdict_ch.category);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (addr_xfer || verdict_xfer) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin : sequencer
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    addr_ch.valid        = 1'b0;
    addr_ch.mode         = pbac_pkg::MODE_CLASSIFY;
    addr_ch.is_ipv6      = 1'b0;
    addr_ch.address_high = '0;
    addr_ch.address_low  = '0;
    addr_ch.rule_index   = '0;
    addr_ch.pfx_len      = '0;
    verdict_ch.ready     = 1'b0;
    addr_xfer            = 1'b0;
    verdict_xfer         = 1'b0;
    mismatches           = 0;
    holds_asked          = 0;
    policy_valid_q       = 1'b1;
    loopback_en_q        = 1'b1;
    private_en_q         = 1'b0;
    link_local_en_q      = 1'b0;
    cgnat_en_q           = 1'b0;
    rule_count_q         = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole table under reset settings so no unwritten entry is read later
    for (int i = 0; i < pbac_pkg::MAX_RULES; i++) backlog.insert(backlog.size(), random_rule(i));
    wait_drained();

    write_reg(REG_SPARE, pbac_pkg::CFG_DATA_W'($urandom));
    write_policy(1, 1, 1, 1, 1, 3);
    queue_rule(0, 1'b0, 128'h0808_0000, 8'd16);
    queue_rule(1, 1'b1, 128'h2001_0db8_0000_0000_0000_0000_0000_0000, 8'd32);
    queue_rule(2, 1'b1, 128'h0000_0000_0000_0000_0000_0000_0000_abcd, 8'd200);  // too long
    queue_addr(1'b0, 128'h7f00_0001);
    queue_addr(1'b0, 128'h0a00_0000);
    queue_addr(1'b0, 128'hac10_0000);
    queue_addr(1'b0, 128'hac1f_ffff);
    queue_addr(1'b0, 128'hac20_0001);
    queue_addr(1'b0, 128'hc0a8_0101);
    queue_addr(1'b0, 128'ha9fe_0001);
    queue_addr(1'b0, 128'h6440_0000);
    queue_addr(1'b0, 128'h647f_ffff);
    queue_addr(1'b0, 128'h6480_0000);
    queue_addr(1'b0, 128'h0808_0404);
    queue_addr(1'b0, 128'hffff_ffff);
    queue_addr(1'b1, 128'h1);
    queue_addr(1'b1, 128'hfc00_0000_0000_0000_0000_0000_0000_0000);
    queue_addr(1'b1, 128'hfdff_ffff_ffff_ffff_ffff_ffff_ffff_ffff);
    queue_addr(1'b1, 128'hfe80_0000_0000_0000_0000_0000_0000_0000);
    queue_addr(1'b1, 128'hfebf_ffff_ffff_ffff_ffff_ffff_ffff_ffff);
    queue_addr(1'b1, 128'hfec0_0000_0000_0000_0000_0000_0000_0000);
    queue_addr(1'b1, 128'h2001_0db8_ffff_0000_0000_0000_0000_0000);
    queue_addr(1'b1, 128'habcd);
    queue_addr(1'b1, 128'habce);
    queue_addr(1'b1, ~128'd0);
    wait_drained();

    // full table with every check on; receiver stalls long so the chain backs up
    write_policy(1, 1, 1, 1, 1, 7'd64);
    run_phase(100, 1'b1);
    write_policy(0, 1, 1, 1, 1, 7'd64);
    run_phase(45, 1'b0);
    write_policy(1, 0, 0, 0, 0, 7'd0);
    run_phase(45, 1'b0);
    write_policy(1, 0, 0, 0, 0, 7'd127);
    run_phase(45, 1'b0);
    write_policy(1, 1, 0, 1, 0, 7'd1);
    run_phase(45, 1'b0);
    write_policy(1, 0, 1, 0, 1, 7'd65);
    run_phase(45, 1'b0);
    repeat (4) begin
      write_policy($urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pbac_pkg::RULE_COUNT_W'($urandom_range(0, 127)));
      run_phase(45, 1'b0);
    end

    repeat (pbac_pkg::MAX_RULES + 16) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
